// ===== rtl/lmsd_pkg.sv =====
`default_nettype none
package lmsd_pkg;

  // Defaults and fixed geometry
  localparam int COLUMNS_DEF = 32;
  localparam int PANEL_ROWS  = 16;
  localparam int HALF_ROWS   = 8;
  localparam int ROW_W       = $clog2(PANEL_ROWS);
  localparam int PIX_W       = 15;
  localparam int COMP_W      = 5;

  // Opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SWAP  = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;

  typedef struct packed {
    logic pix_write;   // store the pixel on the input ports into the user buffer
    logic swap;        // exchange buffer roles
    logic load_scan;   // capture scan row and level
    logic clear_all;   // zero both buffers at the counter address
    logic clear_user;  // zero the user buffer at the counter address
    logic issue_rd;    // read one column pair at the counter address
    logic cnt_inc;
    logic cnt_clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_col_end;  // counter at the last column
    logic cnt_mem_end;  // counter at the last buffer entry
    logic pipe_busy;    // a read is still on its way to the result registers
  } ctrl_status_t;

endpackage
`default_nettype wire

// ===== rtl/led_matrix_scan_driver.sv =====
`default_nettype none
// Double-buffered frame store and row scanner for a 1/8-scan RGB LED panel.
// Command channel: an op is taken on a clock edge where start is high and
// busy is low. Write pixel (op 0) stores one 15-bit pixel in the user buffer
// in that same edge and leaves busy low, so writes go back to back; writes
// outside the panel are dropped. Swap (op 1) exchanges the buffers and then
// zeroes the new user buffer, one entry a cycle; busy stays high until the
// last entry is zeroed. Scan (op 2) reads the upper and lower row of one
// column each cycle through the two read ports of the display buffer and
// gives one result per column on the strobe; each result passes through the
// buffer read registers and then the output registers, one per cycle, with
// last high on the final column. busy stays high through the column walk
// and until the last read has left the buffer read registers. Each result
// holds for exactly one cycle and the receiver cannot stall it.
// After reset both buffers are zeroed in a single pass with busy high; the
// display buffer is then A and the user buffer B.
module led_matrix_scan_driver #(
  parameter int COLUMNS = lmsd_pkg::COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [5:0] pixel_x,
  input  wire logic [4:0] pixel_y,
  input  wire logic [4:0] red,
  input  wire logic [4:0] green,
  input  wire logic [4:0] blue,
  input  wire logic [2:0] scan_row,
  input  wire logic [4:0] level,
  output logic            strobe,
  output logic      [5:0] column,
  output logic      [2:0] row_address,
  output logic            upper_red,
  output logic            upper_green,
  output logic            upper_blue,
  output logic            lower_red,
  output logic            lower_green,
  output logic            lower_blue,
  output logic            last
);

  lmsd_pkg::ctrl_cmd_t    cmd;
  lmsd_pkg::ctrl_status_t status;

  lmsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lmsd_datapath #(
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .scan_row    (scan_row),
    .level       (level),
    .strobe      (strobe),
    .column      (column),
    .row_address (row_address),
    .upper_red   (upper_red),
    .upper_green (upper_green),
    .upper_blue  (upper_blue),
    .lower_red   (lower_red),
    .lower_green (lower_green),
    .lower_blue  (lower_blue),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== rtl/lmsd_frame_ram.sv =====
`default_nettype none
module lmsd_frame_ram #(
  parameter int DEPTH  = lmsd_pkg::COLUMNS_DEF * lmsd_pkg::PANEL_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [lmsd_pkg::PIX_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]          raddr0,
  input  wire logic [ADDR_W-1:0]          raddr1,
  output logic      [lmsd_pkg::PIX_W-1:0] rdata0,
  output logic      [lmsd_pkg::PIX_W-1:0] rdata1
);

  logic [lmsd_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

// ===== rtl/lmsd_ctrl.sv =====
`default_nettype none
module lmsd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [1:0]             op,
  input  wire lmsd_pkg::ctrl_status_t status,
  output lmsd_pkg::ctrl_cmd_t         cmd,
  output logic                        busy
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state != ST_IDLE) || status.pipe_busy;
  assign accept = start && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_INIT: begin
        cmd.clear_all = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (status.cnt_mem_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            lmsd_pkg::OP_WRITE: begin
              cmd.pix_write = 1'b1;
            end
            lmsd_pkg::OP_SWAP: begin
              cmd.swap   = 1'b1;
              state_next = ST_CLEAR;
            end
            lmsd_pkg::OP_SCAN: begin
              cmd.load_scan = 1'b1;
              state_next    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_user = 1'b1;
        cmd.cnt_inc    = 1'b1;
        if (status.cnt_mem_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.issue_rd = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (status.cnt_col_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lmsd_datapath.sv =====
`default_nettype none
module lmsd_datapath #(
  parameter int COLUMNS = lmsd_pkg::COLUMNS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lmsd_pkg::ctrl_cmd_t         cmd,
  output lmsd_pkg::ctrl_status_t           status,
  input  wire logic [5:0]                  pixel_x,
  input  wire logic [4:0]                  pixel_y,
  input  wire logic [4:0]                  red,
  input  wire logic [4:0]                  green,
  input  wire logic [4:0]                  blue,
  input  wire logic [2:0]                  scan_row,
  input  wire logic [4:0]                  level,
  output logic                             strobe,
  output logic      [5:0]                  column,
  output logic      [2:0]                  row_address,
  output logic                             upper_red,
  output logic                             upper_green,
  output logic                             upper_blue,
  output logic                             lower_red,
  output logic                             lower_green,
  output logic                             lower_blue,
  output logic                             last
);

  localparam int DEPTH  = COLUMNS * lmsd_pkg::PANEL_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = lmsd_pkg::COMP_W;

  logic [ADDR_W-1:0]          cnt;
  logic                       display_is_b;
  logic [2:0]                 row;
  logic [CW-1:0]              lvl;
  logic [ADDR_W-1:0]          base_hi;
  logic [ADDR_W-1:0]          base_lo;
  logic [ADDR_W-1:0]          base_next;
  logic                       p1_valid;
  logic [5:0]                 p1_col;
  logic                       p1_last;

  logic                       pix_ok;
  logic [ADDR_W-1:0]          pix_addr;
  logic                       user_we;
  logic                       we_a;
  logic                       we_b;
  logic [ADDR_W-1:0]          waddr;
  logic [lmsd_pkg::PIX_W-1:0] wdata;
  logic [ADDR_W-1:0]          raddr_hi;
  logic [ADDR_W-1:0]          raddr_lo;
  logic [lmsd_pkg::PIX_W-1:0] a_hi;
  logic [lmsd_pkg::PIX_W-1:0] a_lo;
  logic [lmsd_pkg::PIX_W-1:0] b_hi;
  logic [lmsd_pkg::PIX_W-1:0] b_lo;
  logic [lmsd_pkg::PIX_W-1:0] px_hi;
  logic [lmsd_pkg::PIX_W-1:0] px_lo;

  assign status.cnt_col_end = (cnt == ADDR_W'(COLUMNS - 1));
  assign status.cnt_mem_end = (cnt == ADDR_W'(DEPTH - 1));
  assign status.pipe_busy   = p1_valid;

  // Write port: pixel writes take the input address, clear sweeps take the counter
  assign pix_ok   = cmd.pix_write
                    && ({1'b0, pixel_x} < 7'(COLUMNS))
                    && (pixel_y < 5'(lmsd_pkg::PANEL_ROWS));
  assign pix_addr = ADDR_W'(pixel_y[lmsd_pkg::ROW_W-1:0]) * ADDR_W'(COLUMNS)
                    + ADDR_W'(pixel_x);
  assign user_we  = pix_ok || cmd.clear_user;
  assign we_a     = cmd.clear_all || (display_is_b && user_we);
  assign we_b     = cmd.clear_all || (!display_is_b && user_we);
  assign waddr    = cmd.pix_write ? pix_addr : cnt;
  assign wdata    = cmd.pix_write ? {blue, green, red} : '0;

  assign base_next = ADDR_W'(scan_row) * ADDR_W'(COLUMNS);
  assign raddr_hi  = base_hi + cnt;
  assign raddr_lo  = base_lo + cnt;

  lmsd_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_a (
    .clk    (clk),
    .we     (we_a),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr_hi),
    .raddr1 (raddr_lo),
    .rdata0 (a_hi),
    .rdata1 (a_lo)
  );

  lmsd_frame_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame_b (
    .clk    (clk),
    .we     (we_b),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr_hi),
    .raddr1 (raddr_lo),
    .rdata0 (b_hi),
    .rdata1 (b_lo)
  );

  assign px_hi = display_is_b ? b_hi : a_hi;
  assign px_lo = display_is_b ? b_lo : a_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      display_is_b <= 1'b0;
      p1_valid     <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + ADDR_W'(1);
      end
      if (cmd.swap) begin
        display_is_b <= !display_is_b;
      end
      p1_valid <= cmd.issue_rd;
      strobe   <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_scan) begin
      row     <= scan_row;
      lvl     <= level;
      base_hi <= base_next;
      base_lo <= base_next + ADDR_W'(lmsd_pkg::HALF_ROWS * COLUMNS);
    end
    p1_col  <= cnt[5:0];
    p1_last <= status.cnt_col_end;
    column      <= p1_col;
    row_address <= row;
    last        <= p1_last;
    upper_red   <= lvl < px_hi[CW-1:0];
    upper_green <= lvl < px_hi[2*CW-1:CW];
    upper_blue  <= lvl < px_hi[3*CW-1:2*CW];
    lower_red   <= lvl < px_lo[CW-1:0];
    lower_green <= lvl < px_lo[2*CW-1:CW];
    lower_blue  <= lvl < px_lo[3*CW-1:2*CW];
  end

endmodule
`default_nettype wire
